// ===== design/cges_pkg.sv =====
// cges_pkg: shared types and constants of the correlated GBM Euler step block
// item layouts, command codes, register indexes and datapath widths
// no dependencies
`default_nettype none

package cges_pkg;

  // field widths
  localparam int IDX_W      = 3;
  localparam int CMD_W      = 2;
  localparam int FACTOR_W   = 16;
  localparam int SAMPLE_W   = 16;
  localparam int PRICE_W    = 32;
  localparam int RATE_W     = 24;
  localparam int DT_W       = 24;
  localparam int ASSETS_W   = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ASSETS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SQRT_DT  = 2'd2;

  localparam logic [ASSETS_W-1:0] ASSETS_RESET = 4'd8;

  // item commands
  localparam logic [CMD_W-1:0] CMD_LOAD_FACTOR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_ASSET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;

  // datapath widths
  localparam int MAC_W    = 32;  // factor * sample
  localparam int ACC_W    = 35;  // sum of up to eight products
  localparam int RD_W     = 49;  // rate * dt
  localparam int SD_W     = 60;  // shock * sqrt_dt
  localparam int G_W      = 61;  // growth term, Q.50
  localparam int G_SHIFT  = 26;  // Q.50 to Q.24
  localparam int G24_W    = G_W - G_SHIFT;
  localparam int LO_W     = 17;  // low slice of the growth term for the split multiply
  localparam int HI_W     = G24_W - LO_W;
  localparam int PLO_W    = PRICE_W + LO_W;
  localparam int PHI_W    = PRICE_W + HI_W;
  localparam int PROD_W   = 67;
  localparam int D_SHIFT  = 24;  // Q.40 to Q.16
  localparam int DELTA_W  = PROD_W - D_SHIFT;
  localparam int NP_W     = 45;

  localparam logic [G_W-1:0]    G_HALF  = G_W'(64'd1 << (G_SHIFT - 1));
  localparam logic [PROD_W-1:0] D_HALF  = PROD_W'(64'd1 << (D_SHIFT - 1));
  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

  typedef struct packed {
    logic [CMD_W-1:0]           cmd;
    logic [IDX_W-1:0]           row_index;
    logic [IDX_W-1:0]           col_index;
    logic signed [FACTOR_W-1:0] factor_entry;
    logic [PRICE_W-1:0]         spot_price;
    logic signed [RATE_W-1:0]   drift_rate;
    logic signed [SAMPLE_W-1:0] normal_sample;
  } cges_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   asset_index;
    logic [PRICE_W-1:0] price;
    logic               saturated;
    logic               last;
  } cges_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load_factor;
    logic             load_asset;
    logic             load_sample;
    logic [IDX_W-1:0] sample_idx;
    logic             mac_issue;
    logic             mac_first;
    logic             mul_g;
    logic             sum_g;
    logic             round_g;
    logic             mul_lo;
    logic             mul_hi;
    logic             sum_delta;
    logic             write_out;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] j;
    logic             last;
  } cges_ctl_t;

endpackage

`default_nettype wire

// ===== design/cges_ram.sv =====
// cges_ram: generic single write port, single read port RAM
// read data is registered; no dependencies
`default_nettype none

module cges_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/cges_ctrl.sv =====
// cges_ctrl: controller state machine of the correlated GBM Euler step
// decodes items, counts samples, sequences the per-asset datapath steps
// depends on cges_pkg
`default_nettype none

module cges_ctrl #(
  parameter int MAX_ASSETS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire cges_pkg::cges_in_t            in_item,
  input  wire logic [cges_pkg::ASSETS_W-1:0] assets_in_use,
  input  wire logic                          out_free,
  output cges_pkg::cges_ctl_t                ctl
);
  import cges_pkg::*;

  localparam int IW = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;
  localparam int CW = $clog2(MAX_ASSETS + 1);

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_MAC       = 11'b000_0000_0010,
    ST_DRAIN_A   = 11'b000_0000_0100,
    ST_DRAIN_B   = 11'b000_0000_1000,
    ST_MUL_G     = 11'b000_0001_0000,
    ST_SUM_G     = 11'b000_0010_0000,
    ST_ROUND_G   = 11'b000_0100_0000,
    ST_MUL_LO    = 11'b000_1000_0000,
    ST_MUL_HI    = 11'b001_0000_0000,
    ST_SUM_DELTA = 11'b010_0000_0000,
    ST_WRITE     = 11'b100_0000_0000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] n_batch, n_batch_next;
  logic [IW-1:0] k, k_next;
  logic [IW-1:0] j, j_next;
  logic [CW-1:0] n_cur;
  logic [CW-1:0] count_stored;
  logic          row_ok;
  logic          accept;

  // active asset count, clamped to one .. MAX_ASSETS
  always_comb begin
    if (assets_in_use == '0) begin
      n_cur = CW'(1);
    end else if (assets_in_use > ASSETS_W'(MAX_ASSETS)) begin
      n_cur = CW'(MAX_ASSETS);
    end else begin
      n_cur = CW'(assets_in_use);
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign row_ok   = ({1'b0, in_item.row_index} < ASSETS_W'(MAX_ASSETS));

  // next state and datapath commands
  always_comb begin
    state_next   = state;
    count_next   = count;
    n_batch_next = n_batch;
    k_next       = k;
    j_next       = j;
    count_stored = count;
    ctl            = '0;
    ctl.k          = IDX_W'(k);
    ctl.j          = IDX_W'(j);
    ctl.sample_idx = IDX_W'(count);
    ctl.last       = ((CW'(k) + CW'(1)) == n_batch);

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item.cmd)
            CMD_LOAD_FACTOR: begin
              ctl.load_factor = row_ok && (in_item.col_index <= in_item.row_index);
            end
            CMD_LOAD_ASSET: begin
              ctl.load_asset = row_ok;
            end
            CMD_SAMPLE: begin
              if (count < CW'(MAX_ASSETS)) begin
                ctl.load_sample = 1'b1;
                count_stored    = count + CW'(1);
              end
              count_next = count_stored;
              // batch complete: start with asset zero
              if (count_stored >= n_cur) begin
                count_next   = '0;
                n_batch_next = n_cur;
                k_next       = '0;
                j_next       = '0;
                state_next   = ST_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        ctl.mac_issue = 1'b1;
        ctl.mac_first = (j == '0);
        if (j == k) begin
          state_next = ST_DRAIN_A;
        end else begin
          j_next = j + IW'(1);
        end
      end
      ST_DRAIN_A: begin
        state_next = ST_DRAIN_B;
      end
      ST_DRAIN_B: begin
        state_next = ST_MUL_G;
      end
      ST_MUL_G: begin
        ctl.mul_g  = 1'b1;
        state_next = ST_SUM_G;
      end
      ST_SUM_G: begin
        ctl.sum_g  = 1'b1;
        state_next = ST_ROUND_G;
      end
      ST_ROUND_G: begin
        ctl.round_g = 1'b1;
        state_next  = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        ctl.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        ctl.mul_hi = 1'b1;
        state_next = ST_SUM_DELTA;
      end
      ST_SUM_DELTA: begin
        ctl.sum_delta = 1'b1;
        state_next    = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          ctl.write_out = 1'b1;
          if (ctl.last) begin
            state_next = ST_IDLE;
          end else begin
            k_next     = k + IW'(1);
            j_next     = '0;
            state_next = ST_MAC;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      n_batch <= CW'(1);
      k       <= '0;
      j       <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      n_batch <= n_batch_next;
      k       <= k_next;
      j       <= j_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/cges_datapath.sv =====
// cges_datapath: stores, multiply-accumulate pipeline and price update
// factor table in cges_ram, per-asset prices and rates, output register
// depends on cges_pkg and cges_ram
`default_nettype none

module cges_datapath #(
  parameter int MAX_ASSETS = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cges_pkg::cges_ctl_t       ctl,
  input  wire cges_pkg::cges_in_t        in_item,
  input  wire logic [cges_pkg::DT_W-1:0] step_dt,
  input  wire logic [cges_pkg::DT_W-1:0] step_sqrt_dt,
  output logic                           out_free,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output cges_pkg::cges_out_t            out_item
);
  import cges_pkg::*;

  localparam int IW       = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;
  localparam int FT_DEPTH = MAX_ASSETS * MAX_ASSETS;
  localparam int FT_AW    = (FT_DEPTH > 1) ? $clog2(FT_DEPTH) : 1;

  logic        [PRICE_W-1:0]  price_buf [MAX_ASSETS];
  logic signed [RATE_W-1:0]   rate_buf  [MAX_ASSETS];
  logic signed [SAMPLE_W-1:0] sample_buf [MAX_ASSETS];

  logic [FT_AW-1:0]    ft_waddr, ft_raddr;
  logic [FACTOR_W-1:0] ft_rdata;

  logic                       v1, v2, first1, first2;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [MAC_W-1:0]    prod_r;
  logic signed [ACC_W-1:0]    acc;

  logic signed [RD_W-1:0] rd_r;
  logic signed [SD_W-1:0] sd_r;
  logic signed [G_W-1:0]  g_r;
  logic                   neg_r;
  logic [G_W-1:0]         g_inv, g_rnd;
  logic [G24_W-1:0]       g24_r;
  logic [PLO_W-1:0]       plo_r;
  logic [PHI_W-1:0]       phi_r;
  logic [PROD_W-1:0]      psum;
  logic [DELTA_W-1:0]     delta_r;

  logic [PRICE_W-1:0]       price_sel;
  logic signed [RATE_W-1:0] rate_sel;
  logic [NP_W-1:0]          np;
  logic [PRICE_W-1:0]       new_price;
  logic                     new_sat;

  assign price_sel = price_buf[ctl.k[IW-1:0]];
  assign rate_sel  = rate_buf[ctl.k[IW-1:0]];

  // factor table: row-major, write from loads, read during accumulation
  assign ft_waddr = FT_AW'(in_item.row_index) * FT_AW'(MAX_ASSETS) + FT_AW'(in_item.col_index);
  assign ft_raddr = FT_AW'(ctl.k) * FT_AW'(MAX_ASSETS) + FT_AW'(ctl.j);

  cges_ram #(
    .WIDTH (FACTOR_W),
    .DEPTH (FT_DEPTH)
  ) u_factor_ram (
    .clk   (clk),
    .we    (ctl.load_factor),
    .waddr (ft_waddr),
    .wdata (in_item.factor_entry),
    .raddr (ft_raddr),
    .rdata (ft_rdata)
  );

  // asset and sample stores
  always_ff @(posedge clk) begin
    if (ctl.load_asset) begin
      price_buf[in_item.row_index[IW-1:0]] <= in_item.spot_price;
      rate_buf[in_item.row_index[IW-1:0]]  <= in_item.drift_rate;
    end else if (ctl.write_out) begin
      price_buf[ctl.k[IW-1:0]] <= new_price;
    end
    if (ctl.load_sample) begin
      sample_buf[ctl.sample_idx[IW-1:0]] <= in_item.normal_sample;
    end
  end

  // mac pipeline valid and first-term flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      first1 <= 1'b0;
      first2 <= 1'b0;
    end else begin
      v1     <= ctl.mac_issue;
      v2     <= v1;
      first1 <= ctl.mac_first;
      first2 <= first1;
    end
  end

  // mac pipeline: sample fetch, product, accumulate
  always_ff @(posedge clk) begin
    sample_q <= sample_buf[ctl.j[IW-1:0]];
    if (v1) begin
      prod_r <= $signed(ft_rdata) * sample_q;
    end
    if (v2) begin
      acc <= first2 ? ACC_W'(prod_r) : acc + ACC_W'(prod_r);
    end
  end

  // growth term rounded on its magnitude: ~g + half + 1 is |g| + half for negative g
  assign g_inv = neg_r ? ~g_r : g_r;
  assign g_rnd = g_inv + (neg_r ? (G_HALF + G_W'(1)) : G_HALF);

  // delta = price * |g| in Q.40, rounded to Q.16
  assign psum = PROD_W'(plo_r) + (PROD_W'(phi_r) << LO_W) + D_HALF;

  // growth and price multiply steps
  always_ff @(posedge clk) begin
    if (ctl.mul_g) begin
      rd_r <= rate_sel * $signed({1'b0, step_dt});
      sd_r <= acc * $signed({1'b0, step_sqrt_dt});
    end
    if (ctl.sum_g) begin
      g_r   <= (G_W'(rd_r) <<< 6) + G_W'(sd_r);
      neg_r <= (G_W'(rd_r) <<< 6) + G_W'(sd_r) < 0;
    end
    if (ctl.round_g) begin
      g24_r <= g_rnd[G_W-1:G_SHIFT];
    end
    if (ctl.mul_lo) begin
      plo_r <= price_sel * g24_r[LO_W-1:0];
    end
    if (ctl.mul_hi) begin
      phi_r <= price_sel * g24_r[G24_W-1:LO_W];
    end
    if (ctl.sum_delta) begin
      delta_r <= psum[PROD_W-1:D_SHIFT];
    end
  end

  // signed update and clamp to the price range
  always_comb begin
    if (neg_r) begin
      np = NP_W'(price_sel) - NP_W'(delta_r);
    end else begin
      np = NP_W'(price_sel) + NP_W'(delta_r);
    end
    if (np[NP_W-1]) begin
      new_price = '0;
      new_sat   = 1'b1;
    end else if (|np[NP_W-2:PRICE_W]) begin
      new_price = PRICE_MAX;
      new_sat   = 1'b1;
    end else begin
      new_price = np[PRICE_W-1:0];
      new_sat   = 1'b0;
    end
  end

  // output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.write_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.write_out) begin
      out_item.asset_index <= ctl.k;
      out_item.price       <= new_price;
      out_item.saturated   <= new_sat;
      out_item.last        <= ctl.last;
    end
  end

endmodule

`default_nettype wire

// ===== design/correlated_gbm_euler_step_top.sv =====
// Correlated GBM Euler step: loads and non-final samples are accepted back to back.
// A sample that completes a batch of N assets starts the per-asset work and stalls
// input until it ends (asset k: k+1 passes of the single factor*sample MAC, the
// DRAIN_A and DRAIN_B states, six growth and split price-multiply steps, one write
// that waits while the output is stalled). Synchronous active-high reset clears
// control, the sample count and out_valid, and loads the register reset values.
`default_nettype none

module correlated_gbm_euler_step_top #(
  parameter int MAX_ASSETS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [cges_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cges_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire cges_pkg::cges_in_t              in_item,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output cges_pkg::cges_out_t                  out_item
);
  import cges_pkg::*;

  logic [ASSETS_W-1:0] assets_in_use;
  logic [DT_W-1:0]     step_dt;
  logic [DT_W-1:0]     step_sqrt_dt;
  cges_ctl_t           ctl;
  logic                out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      assets_in_use <= ASSETS_RESET;
      step_dt       <= '0;
      step_sqrt_dt  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ASSETS_IN_USE: assets_in_use <= cfg_data[ASSETS_W-1:0];
        REG_STEP_DT:       step_dt       <= cfg_data[DT_W-1:0];
        REG_STEP_SQRT_DT:  step_sqrt_dt  <= cfg_data[DT_W-1:0];
        default: ;
      endcase
    end
  end

  cges_ctrl #(
    .MAX_ASSETS (MAX_ASSETS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .assets_in_use (assets_in_use),
    .out_free      (out_free),
    .ctl           (ctl)
  );

  cges_datapath #(
    .MAX_ASSETS (MAX_ASSETS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .in_item      (in_item),
    .step_dt      (step_dt),
    .step_sqrt_dt (step_sqrt_dt),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item)
  );

endmodule

`default_nettype wire

// ===== design/cges_checker.sv =====
// cges_checker: port-level assertions for the correlated GBM Euler step top
// bound to correlated_gbm_euler_step_top; depends on cges_pkg
`default_nettype none

module cges_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire cges_pkg::cges_out_t out_item
);
  import cges_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // no item is taken while a batch still has results to produce
  a_batch_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last |-> in_stall)
    else $error("item accepted in the middle of a batch");

  // a saturated price sits at one end of the range
  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.saturated |->
      (out_item.price == '0) || (out_item.price == PRICE_MAX))
    else $error("saturated price not clamped");

endmodule

bind correlated_gbm_euler_step_top cges_checker u_cges_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

// ===== sim/cges_checker.sv =====
// cges_scoreboard: watches the item, result and register ports of the correlated GBM
// Euler step block, predicts each step's prices and compares them with the results
// depends on cges_pkg for item layouts, command codes and register indexes
`default_nettype none

module cges_scoreboard (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [cges_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cges_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire cges_pkg::cges_in_t              in_item,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire cges_pkg::cges_out_t             out_item,
  output int                                   fail_count,
  output int                                   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cges_pkg::*;

  localparam int MAX_ASSETS = 8;

  // own copy of the block's stores and registers
  logic signed [FACTOR_W-1:0] factor_m [MAX_ASSETS][MAX_ASSETS];
  logic [PRICE_W-1:0]         price_m  [MAX_ASSETS];
  logic signed [RATE_W-1:0]   rate_m   [MAX_ASSETS];
  logic signed [SAMPLE_W-1:0] sample_m [MAX_ASSETS];
  int unsigned                sample_cnt;
  logic [ASSETS_W-1:0]        assets_cfg;
  logic [DT_W-1:0]            dt_cfg;
  logic [DT_W-1:0]            sqrt_dt_cfg;

  cges_out_t step_results_q[$];
  cges_out_t want;

  initial begin
    fail_count = 0;
    pending = 0;
    sample_cnt = 0;
    assets_cfg = ASSETS_RESET;
    dt_cfg = '0;
    sqrt_dt_cfg = '0;
    for (int r = 0; r < MAX_ASSETS; r++) begin
      price_m[r] = '0;
      rate_m[r] = '0;
      sample_m[r] = '0;
      for (int c = 0; c < MAX_ASSETS; c++) factor_m[r][c] = '0;
    end
  end

  // apply one accepted item; a completed batch queues one new price per asset
  task automatic euler_step(input cges_in_t it);
    int unsigned n;
    longint      shock;
    longint      g;
    logic [63:0] mag;
    logic [63:0] g24;
    logic [95:0] prod;
    logic [95:0] delta;
    logic [95:0] sum;
    cges_out_t   r;
    case (it.cmd)
      CMD_LOAD_FACTOR: begin
        // upper entries are ignored, the factor is lower triangular
        if (it.col_index <= it.row_index)
          factor_m[it.row_index][it.col_index] = it.factor_entry;
      end
      CMD_LOAD_ASSET: begin
        price_m[it.row_index] = it.spot_price;
        rate_m[it.row_index] = it.drift_rate;
      end
      CMD_SAMPLE: begin
        if (sample_cnt < MAX_ASSETS) begin
          sample_m[sample_cnt] = it.normal_sample;
          sample_cnt++;
        end
        // count 0 acts as one asset, counts above the maximum as the maximum
        if (assets_cfg == 0) n = 1;
        else if (assets_cfg > MAX_ASSETS) n = MAX_ASSETS;
        else n = assets_cfg;
        if (sample_cnt >= n) begin
          for (int k = 0; k < n; k++) begin
            shock = 0;
            for (int j = 0; j <= k; j++)
              shock += longint'(factor_m[k][j]) * longint'(sample_m[j]);
            // growth term in Q.50, rounded on its magnitude to Q.24
            g = longint'(rate_m[k]) * longint'(dt_cfg) * 64 + shock * longint'(sqrt_dt_cfg);
            mag = (g < 0) ? 64'(-g) : 64'(g);
            g24 = (mag + 64'd33554432) >> 26;
            // price change in Q.16, rounded half away from zero
            prod = 96'(price_m[k]) * 96'(g24);
            delta = (prod + 96'd8388608) >> 24;
            r.saturated = 1'b0;
            if (g < 0) begin
              if (delta > 96'(price_m[k])) begin
                price_m[k] = '0;
                r.saturated = 1'b1;
              end else begin
                price_m[k] = price_m[k] - delta[PRICE_W-1:0];
              end
            end else begin
              sum = 96'(price_m[k]) + delta;
              if (sum > 96'(PRICE_MAX)) begin
                price_m[k] = PRICE_MAX;
                r.saturated = 1'b1;
              end else begin
                price_m[k] = sum[PRICE_W-1:0];
              end
            end
            r.asset_index = IDX_W'(k);
            r.price = price_m[k];
            r.last = (k + 1 == n);
            step_results_q = {step_results_q, r};
          end
          sample_cnt = 0;
        end
      end
      default: ;
    endcase
  endtask

  // sample all ports at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      sample_cnt = 0;
      assets_cfg = ASSETS_RESET;
      dt_cfg = '0;
      sqrt_dt_cfg = '0;
      step_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ASSETS_IN_USE: assets_cfg = cfg_data[ASSETS_W-1:0];
          REG_STEP_DT:       dt_cfg = cfg_data[DT_W-1:0];
          REG_STEP_SQRT_DT:  sqrt_dt_cfg = cfg_data[DT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) euler_step(in_item);
      if (out_valid && !out_stall) begin
        if (step_results_q.size() == 0) begin
          $display("%0t: unexpected result asset %0d price %h", $time,
                   out_item.asset_index, out_item.price);
          fail_count++;
        end else begin
          want = step_results_q.pop_front();
          if (out_item.asset_index !== want.asset_index) begin
            $display("%0t: asset_index expected %0d actual %0d", $time,
                     want.asset_index, out_item.asset_index);
            fail_count++;
          end
          if (out_item.price !== want.price) begin
            $display("%0t: price of asset %0d expected %h actual %h", $time,
                     want.asset_index, want.price, out_item.price);
            fail_count++;
          end
          if (out_item.saturated !== want.saturated) begin
            $display("%0t: saturated of asset %0d expected %b actual %b", $time,
                     want.asset_index, want.saturated, out_item.saturated);
            fail_count++;
          end
          if (out_item.last !== want.last) begin
            $display("%0t: last of asset %0d expected %b actual %b", $time,
                     want.asset_index, want.last, out_item.last);
            fail_count++;
          end
        end
      end
    end
    pending = step_results_q.size();
  end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// tb: stimulus and verdict for the correlated GBM Euler step block
// drives items, register writes and output stalls; checking is done in cges_scoreboard
// depends on cges_pkg, correlated_gbm_euler_step_top and cges_scoreboard
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cges_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  cges_in_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  cges_out_t             out_item;
  int                    fail_count;
  int                    pending;

  int gap_pct = 0;
  int stall_pct = 0;

  correlated_gbm_euler_step_top #(.MAX_ASSETS(8)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  cges_scoreboard u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // run limit
  initial begin
    #7200000;
    $display("*** FAILED ***");
    $finish;
  end

  // every field random, command fixed
  function automatic cges_in_t rand_item(input logic [CMD_W-1:0] c);
    cges_in_t it;
    it = cges_in_t'({$urandom(), $urandom(), $urandom()});
    it.cmd = c;
    return it;
  endfunction

  // mostly within three sigma, sometimes the full range
  function automatic logic [SAMPLE_W-1:0] draw_normal();
    if ($urandom_range(99) < 80) return SAMPLE_W'(int'($urandom_range(24576)) - 12288);
    return SAMPLE_W'($urandom());
  endfunction

  function automatic logic [PRICE_W-1:0] draw_spot();
    if ($urandom_range(99) < 75) return {4'd0, 12'($urandom()), 16'($urandom())};
    return $urandom();
  endfunction

  function automatic logic [RATE_W-1:0] draw_rate();
    if ($urandom_range(99) < 75) return RATE_W'(int'($urandom_range(2097152)) - 1048576);
    return RATE_W'($urandom());
  endfunction

  // one item through the input handshake, called at a falling edge
  task automatic send(input cges_in_t it);
    while ((gap_pct != 0) && ($urandom_range(99) < gap_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] v);
    cges_in_t it;
    it = rand_item(CMD_SAMPLE);
    it.normal_sample = v;
    send(it);
  endtask

  task automatic send_asset(input int a, input logic [PRICE_W-1:0] spot,
                            input logic [RATE_W-1:0] rate);
    cges_in_t it;
    it = rand_item(CMD_LOAD_ASSET);
    it.row_index = IDX_W'(a);
    it.spot_price = spot;
    it.drift_rate = rate;
    send(it);
  endtask

  task automatic send_factor(input int r, input int c, input logic [FACTOR_W-1:0] v);
    cges_in_t it;
    it = rand_item(CMD_LOAD_FACTOR);
    it.row_index = IDX_W'(r);
    it.col_index = IDX_W'(c);
    it.factor_entry = v;
    send(it);
  endtask

  // wait for every expected result, then for the longest batch to finish
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_regs(input int n, input logic [DT_W-1:0] dt,
                            input logic [DT_W-1:0] sqdt);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_ASSETS_IN_USE;
    cfg_data <= CFG_DATA_W'(n);
    @(negedge clk);
    cfg_index <= REG_STEP_DT;
    cfg_data <= dt;
    @(negedge clk);
    cfg_index <= REG_STEP_SQRT_DT;
    cfg_data <= sqdt;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // stimulus
  initial begin
    int n_sel;
    int counted;
    int pick;
    int ra;
    int ca;
    logic [DT_W-1:0] dt_sel;
    logic [DT_W-1:0] sqdt_sel;
    cges_in_t it;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill the whole lower factor and every asset before any batch
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c <= r; c++) begin
        send_factor(r, c, (r == c) ? FACTOR_W'(16384 - $urandom_range(4096)) :
                                     FACTOR_W'($urandom()));
      end
    end
    for (int a = 0; a < 8; a++) send_asset(a, draw_spot(), draw_rate());

    // reset registers: zero step, prices unchanged, sample extremes
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h1000);
    send_sample(16'hF000);
    send_sample(16'h0800);

    // clamping at the top and at zero
    write_regs(1, 24'hFFFFFF, 24'hFFFFFF);
    send_asset(0, 32'hFFFFFFFF, 24'h7FFFFF);
    send_sample(16'h7FFF);
    send_asset(0, 32'h00010000, 24'h800000);
    send_sample(16'h8000);
    send_sample(16'h7FFF);

    // upper factor entry and the unused command are ignored
    send_factor(1, 5, 16'h7FFF);
    send(rand_item(CMD_UNUSED));

    // loads mid-batch, then the asset count lowered under a partial batch
    write_regs(4, 24'd16384, 24'd1048576);
    send_asset(0, 32'h00640000, 24'h020000);
    send_sample(draw_normal());
    send_asset(2, draw_spot(), draw_rate());
    send_factor(3, 1, FACTOR_W'($urandom()));
    send_sample(draw_normal());
    write_regs(2, 24'd16384, 24'd1048576);
    send_sample(draw_normal());

    // count zero acts as one asset
    write_regs(0, 24'd65536, 24'd4194304);
    send_sample(draw_normal());

    // random phases, each with its own registers and one of four idling patterns
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: n_sel = 15;
        1: n_sel = 1;
        2: n_sel = 8;
        3: n_sel = 3;
        4: n_sel = 6;
        default: n_sel = 2;
      endcase
      case (p)
        1: begin
          dt_sel = 24'hFFFFFF;
          sqdt_sel = 24'hFFFFFF;
        end
        3: begin
          dt_sel = '0;
          sqdt_sel = DT_W'($urandom_range(1 << 22, 1 << 16));
        end
        5: begin
          dt_sel = DT_W'($urandom());
          sqdt_sel = DT_W'($urandom());
        end
        default: begin
          dt_sel = DT_W'($urandom_range(1 << 18, 1 << 10));
          sqdt_sel = DT_W'($urandom_range(1 << 22, 1 << 16));
        end
      endcase
      write_regs(n_sel, dt_sel, sqdt_sel);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 57; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 57; end
        default: begin gap_pct = 22; stall_pct = 22; end
      endcase

      counted = 0;
      while (counted < 24) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_sample(draw_normal());
          counted++;
        end else if (pick < 82) begin
          send_asset($urandom_range(7), draw_spot(), draw_rate());
          counted++;
        end else if (pick < 93) begin
          ra = $urandom_range(7);
          ca = $urandom_range(7);
          send_factor(ra, ca, FACTOR_W'($urandom()));
          if (ca <= ra) counted++;
        end else begin
          it = rand_item(CMD_UNUSED);
          send(it);
        end
      end
      gap_pct = 0;
      stall_pct = 0;
    end

    // wind down and give the verdict
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/cges_pkg.sv
design/cges_ram.sv
design/cges_ctrl.sv
design/cges_datapath.sv
design/correlated_gbm_euler_step_top.sv
design/cges_checker.sv
sim/cges_checker.sv
sim/tb.sv
